>>> rtl/core/apf_pkg.sv
`timescale 1ns / 1ps
package apf_pkg;
  localparam int MAX_VERTICES_DEF = 16;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROOT,
    ST_SCAN,
    ST_BACK,
    ST_VISIT,
    ST_POP,
    ST_PFRAME,
    ST_PVERT,
    ST_DONE
  } state_t;
endpackage

>>> rtl/core/apf_ram.sv
`timescale 1ns / 1ps
module apf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/articulation_point_finder.sv
`timescale 1ns / 1ps
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------
// command   | start / busy            | cmd, row_index, row_bits
// config    | cfg_valid / cfg_ready   | cfg_data (vertex_count)
// result    | done strobe, one cycle  | cut_mask, cut_count
//
// a load beat writes one adjacency row; busy stays low
// a search beat walks every neighbor slot of every vertex one per cycle, except
// that a tree edge also passes ST_VISIT, a back edge ST_BACK, and a pop
// ST_POP, ST_PFRAME and ST_PVERT (a pop of the root returns to ST_ROOT)
// reset clears the adjacency matrix at once; busy is low right after reset
// the result cannot be stalled; done is high for exactly one cycle
module articulation_point_finder
  import apf_pkg::*;
#(
  parameter int MaxV = MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [3:0]  row_index,
  input  logic [15:0] row_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic [15:0] cut_mask,
  output logic [4:0]  cut_count
);
  localparam int AW = $clog2(MaxV);
  localparam int CW = $clog2(MaxV + 1);
  localparam int TW = AW + 1;

  state_t state, state_next;

  logic [4:0]    vcount;
  logic [CW-1:0] n;

  // matrix as flops: edge test needs row a bit b or row b bit a
  logic [MaxV-1:0] adj [MaxV];
  logic [MaxV-1:0] visited;
  logic [MaxV-1:0] has_parent;
  logic [MaxV-1:0] cut;

  // top frame lives in registers, frames below it in the frame ram
  logic [CW-1:0] root;
  logic [CW-1:0] sp;
  logic [AW-1:0] v;
  logic [CW-1:0] nb;
  logic [CW-1:0] children;
  logic [TW-1:0] clk_cnt;
  logic [TW-1:0] low_v;
  logic [TW-1:0] disc_v;
  logic [AW-1:0] par_v;
  logic [TW-1:0] child_low;
  logic [CW-1:0] cut_pop;

  // vertex ram: {disc, low, parent}
  logic          vr_we;
  logic [AW-1:0] vr_waddr, vr_raddr;
  logic [2*TW+AW-1:0] vr_wdata, vr_rdata;
  // frame ram: {vertex, next, children}
  logic          fr_we;
  logic [AW-1:0] fr_waddr, fr_raddr;
  logic [AW+2*CW-1:0] fr_wdata, fr_rdata;

  apf_ram #(.Width(2*TW+AW), .Depth(MaxV)) u_vram (
    .clk(clk), .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
    .raddr(vr_raddr), .rdata(vr_rdata)
  );
  apf_ram #(.Width(AW+2*CW), .Depth(MaxV)) u_fram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  // vertex count saturates at the built maximum
  assign n = (int'(vcount) > MaxV) ? CW'(MaxV) : CW'(vcount);
  assign cfg_ready = (state == ST_IDLE);
  assign busy = (state != ST_IDLE);

  logic [AW-1:0] nb_a;
  logic [AW-1:0] root_a;
  logic [AW-1:0] top_a;
  logic          link;
  logic          scan_end;
  logic          scan_tree;
  logic          scan_back;
  logic [TW-1:0] rd_disc, rd_low;
  logic [AW-1:0] rd_par;
  logic [AW-1:0] fr_vertex;
  logic [CW-1:0] fr_next, fr_kids;

  assign nb_a = nb[AW-1:0];
  assign root_a = root[AW-1:0];
  assign top_a = AW'(sp - CW'(1));
  assign link = adj[v][nb_a] || adj[nb_a][v];
  assign {rd_disc, rd_low, rd_par} = vr_rdata;
  assign {fr_vertex, fr_next, fr_kids} = fr_rdata;

  // scan slot outcome: end of row, unvisited neighbor, back edge, or no edge
  // (the edge to the parent of a non-root vertex is skipped)
  assign scan_end = (nb >= n);
  assign scan_tree = !scan_end && link && !visited[nb_a];
  assign scan_back = !scan_end && link && visited[nb_a] &&
                     !(has_parent[v] && nb_a == par_v);

  // popcount of the cut flags
  always_comb begin
    cut_pop = '0;
    for (int i = 0; i < MaxV; i++) cut_pop = cut_pop + CW'(cut[i]);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start && cmd == CMD_SEARCH) state_next = ST_INIT;
      ST_INIT:   state_next = ST_ROOT;
      ST_ROOT: begin
        if (root >= n) state_next = ST_DONE;
        else if (!visited[root_a]) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_next = ST_POP;
        else if (scan_tree) state_next = ST_VISIT;
        else if (scan_back) state_next = ST_BACK;
      end
      ST_BACK:   state_next = ST_SCAN;
      ST_VISIT:  state_next = ST_SCAN;
      ST_POP:    state_next = (sp == CW'(1)) ? ST_ROOT : ST_PFRAME;
      ST_PFRAME: state_next = ST_PVERT;
      ST_PVERT:  state_next = ST_SCAN;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    vr_we = 1'b0;
    vr_waddr = v;
    vr_wdata = {disc_v, low_v, par_v};
    vr_raddr = nb_a;
    fr_we = 1'b0;
    fr_waddr = top_a;
    fr_wdata = {v, nb + CW'(1), children + CW'(1)};
    fr_raddr = AW'(sp - CW'(2));
    unique case (state)
      ST_ROOT: begin
        vr_waddr = root_a;
        vr_wdata = {clk_cnt, clk_cnt, {AW{1'b0}}};
        vr_we = (root < n) && !visited[root_a];
      end
      ST_SCAN: begin
        // descending: save this frame and the low link of v
        vr_we = scan_tree;
        fr_we = scan_tree;
      end
      ST_VISIT: begin
        vr_waddr = nb_a;
        vr_wdata = {clk_cnt, clk_cnt, v};
        vr_we = 1'b1;
      end
      ST_PFRAME: begin
        // parent frame arrives; fetch its vertex record
        vr_raddr = fr_vertex;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vcount <= 5'd16;
      done <= 1'b0;
      cut_mask <= '0;
      cut_count <= '0;
      for (int i = 0; i < MaxV; i++) adj[i] <= '0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
      if (cfg_valid && cfg_ready) begin
        vcount <= cfg_data;
      end
      // rows past the built maximum are dropped
      if (start && !busy && cmd == CMD_LOAD && int'(row_index) < MaxV) begin
        adj[AW'(row_index)] <= MaxV'(row_bits);
      end
      unique case (state)
        ST_INIT: begin
          visited <= '0;
          has_parent <= '0;
          cut <= '0;
          root <= '0;
          clk_cnt <= '0;
        end
        ST_ROOT: begin
          if (root < n) begin
            if (!visited[root_a]) begin
              visited[root_a] <= 1'b1;
              v <= root_a;
              par_v <= '0;
              disc_v <= clk_cnt;
              low_v <= clk_cnt;
              nb <= '0;
              children <= '0;
              sp <= CW'(1);
              clk_cnt <= clk_cnt + TW'(1);
            end
            root <= root + CW'(1);
          end
        end
        ST_SCAN: begin
          if (!scan_end && !scan_tree && !scan_back) nb <= nb + CW'(1);
        end
        ST_BACK: begin
          // discovery time of the neighbor read in the scan cycle
          if (rd_disc < low_v) low_v <= rd_disc;
          nb <= nb + CW'(1);
        end
        ST_VISIT: begin
          visited[nb_a] <= 1'b1;
          has_parent[nb_a] <= 1'b1;
          v <= nb_a;
          par_v <= v;
          disc_v <= clk_cnt;
          low_v <= clk_cnt;
          nb <= '0;
          children <= '0;
          sp <= sp + CW'(1);
          clk_cnt <= clk_cnt + TW'(1);
        end
        ST_POP: begin
          child_low <= low_v;
          sp <= sp - CW'(1);
        end
        ST_PFRAME: begin
          v <= fr_vertex;
          nb <= fr_next;
          children <= fr_kids;
        end
        ST_PVERT: begin
          // fold child low into parent and test the parent
          disc_v <= rd_disc;
          par_v <= rd_par;
          low_v <= (child_low < rd_low) ? child_low : rd_low;
          if (!has_parent[v]) begin
            if (children > CW'(1)) cut[v] <= 1'b1;
          end else if (child_low >= rd_disc) begin
            cut[v] <= 1'b1;
          end
        end
        ST_DONE: begin
          cut_mask <= 16'(cut);
          cut_count <= 5'(cut_pop);
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst) cfg_ready |-> !busy)
    else $error("config ready while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> cut_count <= 5'(MaxV))
    else $error("cut count out of range");
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> sp != '0)
    else $error("scan with empty stack");
`endif
endmodule

>>> tb/apf_checker.sv
`timescale 1ns / 1ps
module apf_checker
  import apf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        cmd,
  input  logic [3:0]  row_index,
  input  logic [15:0] row_bits,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        done,
  input  logic [15:0] cut_mask,
  input  logic [4:0]  cut_count,
  output int          errors,
  output int          pending
);
  typedef struct packed {
    logic [15:0] mask;
    logic [4:0]  count;
  } cut_result_t;

  logic [15:0] adj_rows [16];
  logic [4:0]  nverts;
  cut_result_t cut_queue [$];

  function automatic cut_result_t find_cuts(input int n);
    logic [15:0] seen, cuts;
    int disc [16], low [16], par [16];
    int stk [16], nxt [16], kids [16];
    int sp, clk_t, v, nb, u, cnt;
    bit edge_ok;
    cut_result_t r;
    seen = '0;
    cuts = '0;
    clk_t = 0;
    for (int i = 0; i < 16; i++) par[i] = -1;
    for (int root = 0; root < n; root++) begin
      if (seen[root]) continue;
      sp = 0;
      seen[root] = 1'b1;
      disc[root] = clk_t;
      low[root] = clk_t;
      clk_t++;
      stk[0] = root;
      nxt[0] = 0;
      kids[0] = 0;
      sp = 1;
      while (sp > 0) begin
        v = stk[sp-1];
        if (nxt[sp-1] < n) begin
          nb = nxt[sp-1];
          nxt[sp-1]++;
          edge_ok = adj_rows[v][nb] || adj_rows[nb][v];
          if (!edge_ok) continue;
          if (!seen[nb]) begin
            par[nb] = v;
            kids[sp-1]++;
            seen[nb] = 1'b1;
            disc[nb] = clk_t;
            low[nb] = clk_t;
            clk_t++;
            stk[sp] = nb;
            nxt[sp] = 0;
            kids[sp] = 0;
            sp++;
          end else if (nb != par[v]) begin
            if (disc[nb] < low[v]) low[v] = disc[nb];
          end
        end else begin
          sp--;
          if (sp > 0) begin
            u = stk[sp-1];
            if (low[v] < low[u]) low[u] = low[v];
            if (par[u] < 0) begin
              if (kids[sp-1] > 1) cuts[u] = 1'b1;
            end else if (low[v] >= disc[u]) begin
              cuts[u] = 1'b1;
            end
          end
        end
      end
    end
    cnt = 0;
    for (int i = 0; i < n; i++) cnt += cuts[i];
    r.mask = cuts;
    r.count = 5'(cnt);
    return r;
  endfunction

  assign pending = cut_queue.size();

  always @(posedge clk) begin
    cut_result_t exp_r;
    int bad;
    bad = 0;
    if (rst) begin
      for (int i = 0; i < 16; i++) adj_rows[i] <= '0;
      nverts <= 5'd16;
      errors <= 0;
      cut_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) nverts <= cfg_data;
      if (start && !busy) begin
        if (cmd == CMD_LOAD) adj_rows[row_index] <= row_bits;
        else cut_queue.insert(cut_queue.size(),
                              find_cuts(nverts > 16 ? 16 : int'(nverts)));
      end
      if (done) begin
        if (cut_queue.size() == 0) begin
          $error("result with nothing expected: cut_mask %h", cut_mask);
          bad++;
        end else begin
          exp_r = cut_queue.pop_front();
          if (cut_mask !== exp_r.mask) begin
            $error("cut_mask expected %h actual %h", exp_r.mask, cut_mask);
            bad++;
          end
          if (cut_count !== exp_r.count) begin
            $error("cut_count expected %0d actual %0d", exp_r.count, cut_count);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import apf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd = CMD_LOAD;
  logic [3:0]  row_index = '0;
  logic [15:0] row_bits = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        done;
  logic [15:0] cut_mask;
  logic [4:0]  cut_count;
  int          errors;
  int          pending;
  int          cycles = 0;
  logic [4:0]  cur_n = 5'd16;

  always #10 clk = ~clk;

  articulation_point_finder u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .row_index(row_index), .row_bits(row_bits), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
    .cut_mask(cut_mask), .cut_count(cut_count)
  );

  apf_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .row_index(row_index), .row_bits(row_bits), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
    .cut_mask(cut_mask), .cut_count(cut_count), .errors(errors),
    .pending(pending)
  );

  // watchdog for ~2000 beats with their searches and gaps
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one command beat; start stays high until the caller idles or the next beat
  task automatic send_beat(input logic c, input logic [3:0] r, input logic [15:0] b,
                           input bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 5) : 0;
    if (wait_n > 0) begin
      start <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    row_index <= r;
    row_bits <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and wait for every expected result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_n(input logic [4:0] n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_n = (n > 16) ? 5'd16 : n;
  endtask

  // random graph: edges among the first k vertices, density p/8, about one row in ten noise
  task automatic load_graph(input int k, input int p);
    logic [15:0] row;
    for (int v = 0; v < 16; v++) begin
      row = '0;
      if (v < k)
        for (int j = 0; j < k; j++)
          if ($urandom_range(0, 7) < p) row[j] = 1'b1;
      if ($urandom_range(0, 9) == 0) row = 16'($urandom);
      send_beat(CMD_LOAD, 4'(v), row, 1'b1);
    end
  endtask

  initial begin
    int k, sizes[6];
    sizes = '{1, 2, 0, 16, 31, 9};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: empty graph at reset size, then a path, a star, a self loop
    send_beat(CMD_SEARCH, 4'd0, 16'h0, 1'b0);
    for (int v = 0; v < 15; v++) send_beat(CMD_LOAD, 4'(v), 16'(1 << (v + 1)), 1'b0);
    send_beat(CMD_SEARCH, 4'd0, 16'hffff, 1'b0);
    send_beat(CMD_LOAD, 4'd15, 16'hffff, 1'b0);   // hub plus self loop
    send_beat(CMD_SEARCH, 4'd15, 16'h0, 1'b0);
    // row replaced, not merged
    send_beat(CMD_LOAD, 4'd15, 16'h0001, 1'b0);
    send_beat(CMD_SEARCH, 4'd0, 16'h0, 1'b0);
    send_beat(CMD_LOAD, 4'd7, 16'h0000, 1'b0);
    send_beat(CMD_SEARCH, 4'd0, 16'h0, 1'b0);

    // sweep vertex counts including zero and the saturating extreme
    foreach (sizes[i]) begin
      write_n(5'(sizes[i]));
      load_graph(cur_n, $urandom_range(1, 4));
      send_beat(CMD_SEARCH, 4'($urandom), 16'($urandom), 1'b1);
    end

    // random part: mostly graphs shaped for the current size, some noise
    for (int g = 0; g < 125; g++) begin
      if (g % 20 == 19) write_n(5'($urandom_range(0, 31)));
      if (g % 37 == 5) drain();   // sender holds until all results are in
      k = (cur_n == 0) ? 0 : $urandom_range(1, cur_n);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8))
          send_beat(1'($urandom), 4'($urandom), 16'($urandom), 1'b1);
      end else begin
        load_graph(k, $urandom_range(0, 6));
      end
      send_beat(CMD_SEARCH, 4'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
    end
    write_n(5'd16);
    send_beat(CMD_SEARCH, 4'd0, 16'h0, 1'b0);

    drain();
    @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
